>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL file that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> src/lmlc_pkg.sv
// ----------------------------------------------------------------------------
// lmlc_pkg
// Shared types, register codes and helper functions of the line match level
// classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lmlc_pkg;

  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_WORDS  = 4;
  localparam int CHARS_W    = NUM_WORDS * CFG_DATA_W;

  typedef enum logic [1:0] {
    LEVEL_NONE   = 2'd0,
    LEVEL_FUZZY  = 2'd1,
    LEVEL_NOCASE = 2'd2,
    LEVEL_EXACT  = 2'd3
  } level_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_CHARS_A        = 3'd1,
    REG_CHARS_B        = 3'd2,
    REG_CHARS_C        = 3'd3,
    REG_CHARS_D        = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0]   length;
    logic [CHARS_W-1:0] chars;   // char i in bits 8i upward
  } pattern_cfg_t;

  typedef struct packed {
    logic   valid;
    level_t level;
  } core_result_t;

  // Fold ASCII upper case letters to lower case; everything else passes.
  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic is_upper;
    is_upper = (c >= 8'h41) && (c <= 8'h5A);
    return is_upper ? (c + 8'h20) : c;
  endfunction

endpackage
`default_nettype wire

>>> src/lmlc_if.sv
// ----------------------------------------------------------------------------
// lmlc_char_if / lmlc_level_if
// Valid/ready channels for line characters in and match levels out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface lmlc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_char;
  logic       end_of_line;

  modport source (output valid, output line_char, output end_of_line, input ready);
  modport sink   (input valid, input line_char, input end_of_line, output ready);
endinterface

interface lmlc_level_if;
  logic       valid;
  logic       ready;
  logic [1:0] grade;

  modport source (output valid, output grade, input ready);
  modport sink   (input valid, input grade, output ready);
endinterface
`default_nettype wire

>>> src/lmlc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lmlc_cfg_regs
// Pattern length and pattern character registers behind the write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lmlc_cfg_regs
  import lmlc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output pattern_cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH: cfg.length <= cfg_data[LEN_W-1:0];
        REG_CHARS_A: cfg.chars[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        REG_CHARS_B: cfg.chars[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        REG_CHARS_C: cfg.chars[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        REG_CHARS_D: cfg.chars[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/lmlc_core.sv
// ----------------------------------------------------------------------------
// lmlc_core
// Per-line match state: shift-and vectors for exact and case-folded
// substrings, subsequence counter, and the level decision at line end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lmlc_core
  import lmlc_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic [CHAR_W-1:0] line_char,
  input  wire logic              end_of_line,
  input  wire pattern_cfg_t      cfg,
  output core_result_t           result
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam logic [MAX_PATTERN-1:0] LSB_ONE = MAX_PATTERN'(1);

  logic [MAX_PATTERN-1:0] exact_progress, exact_progress_next;
  logic [MAX_PATTERN-1:0] nocase_progress, nocase_progress_next;
  logic [CW-1:0]          fuzzy_count, fuzzy_count_next;
  logic                   exact_found, exact_found_next;
  logic                   nocase_found, nocase_found_next;

  logic [CW-1:0]          used_len;
  logic [MAX_PATTERN-1:0] exact_mask, nocase_mask, top_sel;
  logic [CHAR_W-1:0]      lc, pchar, fuzzy_char;
  logic [4:0]             fuzzy_idx;
  logic                   fuzzy_hit;

  assign used_len = (cfg.length > LEN_W'(MAX_PATTERN)) ? CW'(MAX_PATTERN)
                                                         : CW'(cfg.length);
  assign lc = fold_case(line_char);

  always_comb begin
    exact_mask  = '0;
    nocase_mask = '0;
    top_sel     = '0;
    pchar       = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pchar          = cfg.chars[8*i +: 8];
      exact_mask[i]  = (CW'(i) < used_len) && (pchar == line_char);
      nocase_mask[i] = (CW'(i) < used_len) && (fold_case(pchar) == lc);
      top_sel[i]     = (CW'(i + 1) == used_len);
    end
  end

  // Next pattern char for the subsequence walk; only meaningful while count < len.
  assign fuzzy_idx  = 5'(fuzzy_count);
  assign fuzzy_char = cfg.chars[{fuzzy_idx, 3'b000} +: 8];
  assign fuzzy_hit  = (fuzzy_count < used_len) && (fold_case(fuzzy_char) == lc);

  always_comb begin
    exact_progress_next  = ((exact_progress << 1) | LSB_ONE) & exact_mask;
    nocase_progress_next = ((nocase_progress << 1) | LSB_ONE) & nocase_mask;
    exact_found_next     = exact_found  || (|(exact_progress_next & top_sel));
    nocase_found_next    = nocase_found || (|(nocase_progress_next & top_sel));
    fuzzy_count_next     = fuzzy_hit ? fuzzy_count + CW'(1) : fuzzy_count;

    result.valid = advance && end_of_line;
    if ((used_len == '0) || exact_found_next) begin
      result.level = LEVEL_EXACT;
    end else if (nocase_found_next) begin
      result.level = LEVEL_NOCASE;
    end else if (fuzzy_count_next >= used_len) begin
      result.level = LEVEL_FUZZY;
    end else begin
      result.level = LEVEL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && end_of_line)) begin
      exact_progress  <= '0;
      nocase_progress <= '0;
      fuzzy_count     <= '0;
      exact_found     <= 1'b0;
      nocase_found    <= 1'b0;
    end else if (advance) begin
      exact_progress  <= exact_progress_next;
      nocase_progress <= nocase_progress_next;
      fuzzy_count     <= fuzzy_count_next;
      exact_found     <= exact_found_next;
      nocase_found    <= nocase_found_next;
    end
  end

endmodule
`default_nettype wire

>>> src/line_match_level_classifier_unit.sv
// Path: a line's last character gives its match level through the input
//   register, then the result register; a stall can hold it in between.
// Throughput: 1 character per cycle while the result side keeps up; all
//   pattern positions are matched in the single stage between the registers.
// Reset: synchronous, active high; clears pattern registers, line state and
//   both valid flags. No clearing pass; a request is taken the cycle after.
// ----------------------------------------------------------------------------
// line_match_level_classifier_unit
// Streams text lines one character per request and reports, at each line
// end, whether the configured pattern occurs exactly, ignoring case, as a
// fuzzy subsequence, or not at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module line_match_level_classifier_unit
  import lmlc_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  lmlc_char_if.sink                  char_in,
  lmlc_level_if.source               level_out
);

  pattern_cfg_t      cfg;
  core_result_t      core_res;

  // Input register: one character request waiting for the match stage.
  logic              in_vld;
  logic [CHAR_W-1:0] in_char;
  logic              in_eol;

  // Result register: one level waiting for the downstream side.
  logic              out_vld;
  level_t            out_level;

  logic              stage_go;

  // Configuration storage.
  lmlc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the held character whenever the result register can take what it
  // may produce: the slot is empty or its level leaves this cycle.
  assign stage_go = in_vld && (!out_vld || level_out.ready);

  // Take a new request when the input register is empty or drains this cycle.
  assign char_in.ready = !in_vld || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (char_in.ready) begin
      in_vld <= char_in.valid;
    end
  end

  // Payload holds while stalled; no reset needed.
  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      in_char <= char_in.line_char;
      in_eol  <= char_in.end_of_line;
    end
  end

  // Match state and level decision.
  lmlc_core #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (stage_go),
    .line_char   (in_char),
    .end_of_line (in_eol),
    .cfg         (cfg),
    .result      (core_res)
  );

  // Load a level at line end; drop the valid flag once it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (core_res.valid) begin
      out_vld <= 1'b1;
    end else if (level_out.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res.valid) begin
      out_level <= core_res.level;
    end
  end

  assign level_out.valid = out_vld;
  assign level_out.grade = out_level;

  // A line end that leaves the stage must show up as a waiting level.
  `ASSERT_NEXT(a_eol_gives_result, clk, rst, stage_go && in_eol, out_vld)

  // An empty pattern always reports an exact match.
  `ASSERT_NEXT(a_empty_is_exact, clk, rst,
               stage_go && in_eol && (cfg.length == '0), out_level == LEVEL_EXACT)

  // A held character must not advance while a level is stuck downstream.
  `ASSERT_IMPLIES(a_no_overrun, clk, rst, out_vld && !level_out.ready, !stage_go)

endmodule
`default_nettype wire

>>> tb/match_level_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match_level_checker
// Watches the pattern register port and both request channels, predicts the
// match level of every line end and compares it with the level the block
// returns. Hands failure, pending and checked counts to the bench top.
// ----------------------------------------------------------------------------
module match_level_checker
  import lmlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lmlc_char_if                  chars,
  lmlc_level_if                 levels,
  output int                    failures,
  output int                    pending,
  output int                    checked
);

  level_t             expected_levels [$];
  level_t             want;
  logic [LEN_W-1:0]   pat_len;
  logic [CHARS_W-1:0] pat_chars;
  logic [31:0]        exact_run;
  logic [31:0]        nocase_run;
  int                 subseq_done;
  bit                 exact_hit;
  bit                 nocase_hit;
  int                 fail_count  = 0;
  int                 check_count = 0;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  task automatic clear_line_state();
    exact_run   = '0;
    nocase_run  = '0;
    subseq_done = 0;
    exact_hit   = 1'b0;
    nocase_hit  = 1'b0;
  endtask

  // Advance the line state by one character; queue a level at a line end.
  task automatic classify_char(input logic [7:0] c, input logic eol);
    int          n;
    logic [31:0] exact_mask;
    logic [31:0] nocase_mask;
    logic [7:0]  p;
    level_t      lvl;
    n           = (pat_len > 6'd32) ? 32 : int'(pat_len);
    exact_mask  = '0;
    nocase_mask = '0;
    for (int i = 0; i < n; i++) begin
      p = pat_chars[8*i +: 8];
      if (p == c) exact_mask[i] = 1'b1;
      if (to_lower(p) == to_lower(c)) nocase_mask[i] = 1'b1;
    end
    exact_run  = {exact_run[30:0], 1'b1} & exact_mask;
    nocase_run = {nocase_run[30:0], 1'b1} & nocase_mask;
    if (n > 0) begin
      if (exact_run[n-1]) exact_hit = 1'b1;
      if (nocase_run[n-1]) nocase_hit = 1'b1;
    end
    if (subseq_done < n && to_lower(pat_chars[8*subseq_done +: 8]) == to_lower(c))
      subseq_done++;
    if (eol) begin
      if (n == 0 || exact_hit) lvl = LEVEL_EXACT;
      else if (nocase_hit) lvl = LEVEL_NOCASE;
      else if (subseq_done >= n) lvl = LEVEL_FUZZY;
      else lvl = LEVEL_NONE;
      expected_levels.push_back(lvl);
      clear_line_state();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_levels.delete();
      pat_len   = '0;
      pat_chars = '0;
      clear_line_state();
    end else begin
      if (levels.valid && levels.ready) begin
        if (expected_levels.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: match level %0d returned with no line end pending",
                     $realtime, levels.grade);
          fail_count++;
        end else begin
          want = expected_levels.pop_front();
          check_count++;
          if (levels.grade !== want) begin
            if (fail_count < 10)
              $display("%0t: match level mismatch: expected %0d (%s), got %0d",
                       $realtime, want, want.name(), levels.grade);
            fail_count++;
          end
        end
      end
      if (chars.valid && chars.ready)
        classify_char(chars.line_char, chars.end_of_line);
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
          REG_CHARS_A:        pat_chars[0   +: 64] = cfg_data;
          REG_CHARS_B:        pat_chars[64  +: 64] = cfg_data;
          REG_CHARS_C:        pat_chars[128 +: 64] = cfg_data;
          REG_CHARS_D:        pat_chars[192 +: 64] = cfg_data;
          default: ;
        endcase
      end
    end
    failures <= fail_count;
    pending  <= expected_levels.size();
    checked  <= check_count;
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench top for the line match level classifier: drives lines of characters
// and pattern settings, throttles both channels at random and leaves all
// prediction and comparison to the checker placed beside the block.
// ----------------------------------------------------------------------------
module tb;
  import lmlc_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES     = 8;
  // Noise alphabet: letters of both cases plus the bytes just outside A-Z and
  // a-z, which must not fold onto each other.
  localparam logic [79:0] SYMBOLS = "aAbBzZ@[`{";

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int failures;
  int pending;
  int levels_checked;

  lmlc_char_if  char_bus ();
  lmlc_level_if level_bus ();

  line_match_level_classifier_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .char_in   (char_bus),
    .level_out (level_bus)
  );

  match_level_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chars     (char_bus),
    .levels    (level_bus),
    .failures  (failures),
    .pending   (pending),
    .checked   (levels_checked)
  );

  // Current pattern as the bench sees it, and the line being built.
  logic [7:0] pat [32];
  int         pat_used;
  logic [7:0] text [$];

  bit calm;        // no idling on either side while set
  int hold_left;   // output stall cycles still to serve
  int chars_sent;
  int lines_sent;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: serve a requested hold-off first, otherwise take results
  // freely in a calm stretch or idle about one cycle in five.
  initial begin
    level_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        level_bus.ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        level_bus.ready <= 1'b1;
      end else begin
        level_bus.ready <= ($urandom_range(99) >= 19);
      end
    end
  end

  // Toggle case of a letter half of the time; leave other bytes alone.
  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(1) == 1)
      return c ^ 8'h20;
    return c;
  endfunction

  // Noise byte: often a pattern character, so partial and overlapping
  // prefixes show up, else a boundary letter or any byte at all.
  function automatic logic [7:0] pick_symbol(input bit wide);
    int k;
    if (pat_used > 0 && $urandom_range(3) == 0)
      return flip_case(pat[$urandom_range(pat_used - 1)]);
    if (wide && $urandom_range(1) == 1)
      return 8'($urandom_range(255));
    k = $urandom_range(9);
    return SYMBOLS[8*k +: 8];
  endfunction

  // Offer one request and hold it until it is taken. Valid is only lowered
  // for an idle cycle, never dropped and raised in the same step.
  task automatic offer(input logic [7:0] c, input bit eol);
    if (!calm) begin
      while ($urandom_range(99) < 19) begin
        char_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    char_bus.valid       <= 1'b1;
    char_bus.line_char   <= c;
    char_bus.end_of_line <= eol;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (text[i]) offer(text[i], i == text.size() - 1);
    lines_sent++;
  endtask

  task automatic send_text(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_line();
  endtask

  // Stop offering and wait until every line end has its level back, then
  // allow the pipeline to settle before touching the registers.
  task automatic drain();
    char_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write all five pattern registers from pat[]; the length word carries
  // random upper bits that the block must ignore.
  task automatic set_pattern(input int len);
    logic [CHARS_W-1:0]    packed_chars;
    logic [CFG_DATA_W-1:0] words [5];
    cfg_reg_t              order [5];
    for (int i = 0; i < 32; i++) packed_chars[8*i +: 8] = pat[i];
    words[0]            = {$urandom, $urandom};
    words[0][LEN_W-1:0] = len[LEN_W-1:0];
    for (int k = 1; k < 5; k++) words[k] = packed_chars[64*(k-1) +: 64];
    order = '{REG_PATTERN_LENGTH, REG_CHARS_A, REG_CHARS_B, REG_CHARS_C, REG_CHARS_D};
    for (int k = 0; k < 5; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= order[k];
      cfg_data  <= words[k];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
    pat_used = (len > 32) ? 32 : len;
    settings_used++;
  endtask

  task automatic new_pattern(input int len, input bit wide);
    pat_used = 0;
    for (int i = 0; i < 32; i++)
      pat[i] = (i < len) ? pick_symbol(wide) : 8'($urandom_range(255));
    set_pattern(len);
  endtask

  // Build one line: the pattern planted whole, case flipped, spread out as a
  // subsequence or broken, between stretches of noise; a few lines are noise.
  task automatic build_line(input bit wide);
    int kind;
    int gap;
    kind = (pat_used == 0) ? 9 : $urandom_range(9);
    gap  = (pat_used > 0) ? $urandom_range(pat_used - 1) : 0;
    text.delete();
    repeat ($urandom_range(3)) text.push_back(pick_symbol(wide));
    case (kind)
      0, 1, 2: for (int i = 0; i < pat_used; i++) text.push_back(pat[i]);
      3, 4:    for (int i = 0; i < pat_used; i++) text.push_back(flip_case(pat[i]));
      5, 6: begin
        for (int i = 0; i < pat_used; i++) begin
          text.push_back(flip_case(pat[i]));
          if ($urandom_range(1) == 1) text.push_back(pick_symbol(wide));
        end
      end
      7, 8: begin
        for (int i = 0; i < pat_used; i++) begin
          if (i != gap) text.push_back(pat[i]);
          else if ($urandom_range(1) == 1) text.push_back(pick_symbol(wide));
        end
      end
      default: repeat ($urandom_range(1, 10)) text.push_back(pick_symbol(wide));
    endcase
    repeat ($urandom_range(3)) text.push_back(pick_symbol(wide));
    if (text.size() == 0) text.push_back(pick_symbol(wide));
  endtask

  task automatic run_random(input int n_chars, input bit wide);
    int start;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      build_line(wide);
      send_line();
    end
    drain();
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_write            <= 1'b0;
    cfg_index            <= REG_PATTERN_LENGTH;
    cfg_data             <= '0;
    char_bus.valid       <= 1'b0;
    char_bus.line_char   <= '0;
    char_bus.end_of_line <= 1'b0;
    calm      = 1'b0;
    hold_left = 0;
    pat_used  = 0;
    for (int i = 0; i < 32; i++) pat[i] = 8'($urandom_range(255));
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset pattern is empty: any line, even of zero and all-ones bytes,
    // reports exact.
    text.delete();
    text.push_back(8'h00);
    text.push_back(8'hFF);
    send_line();
    drain();

    // Mixed-case pattern: exact hit, case-only hit, spread-out subsequence,
    // and a line shorter than the pattern.
    pat[0] = "a";
    pat[1] = "B";
    pat[2] = "c";
    set_pattern(3);
    send_text("xaBcx");
    send_text("ABC");
    send_text("aXbYc");
    send_text("ab");
    drain();

    // Overlapping prefix: the first "a" starts a false lead.
    pat[0] = "a";
    pat[1] = "a";
    pat[2] = "b";
    set_pattern(3);
    send_text("aaab");
    drain();

    // Short patterns over a tight alphabet hit all four levels often.
    repeat (3) begin
      new_pattern($urandom_range(1, 4), 1'b0);
      run_random(30, 1'b0);
    end

    // Calm stretch: both sides run flat out.
    calm = 1'b1;
    new_pattern(3, 1'b0);
    run_random(40, 1'b0);
    calm = 1'b0;

    // Full-width pattern, then a length above the maximum that must clamp.
    new_pattern(32, 1'b0);
    run_random(40, 1'b0);
    new_pattern(63, 1'b0);
    run_random(30, 1'b0);

    // Empty pattern over arbitrary bytes, then random lengths and bytes.
    new_pattern(0, 1'b1);
    run_random(15, 1'b1);
    repeat (2) begin
      new_pattern($urandom_range(0, 63), 1'b1);
      run_random(20, 1'b1);
    end

    // Back-pressure: hold the result side off while one-character lines keep
    // coming, so the block fills and stalls its input; drain() then pauses
    // the sender until every level is back.
    new_pattern(1, 1'b0);
    hold_left = HOLD_OFF_CYCLES;
    repeat (40) begin
      text.delete();
      text.push_back(pick_symbol(1'b0));
      send_line();
    end
    drain();

    $display("Sent %0d characters in %0d lines under %0d pattern settings (empty, clamped,",
             chars_sent, lines_sent, settings_used);
    $display("full width, random bytes), with a %0d-cycle output stall; %0d levels checked.",
             HOLD_OFF_CYCLES, levels_checked);
    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
